@@ hw/rtl/c2t_pkg.sv @@
// Shared widths, character codes, mode, state and error codes of the CSV to TSV converter.
package c2t_pkg;

  // Width of the line and offset counters; they saturate at all ones.
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned CHAR_W     = 21;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned REPORT_W   = 32;

  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Characters of interest to the parser.
  localparam char_t CH_TAB   = 21'h00_0009;
  localparam char_t CH_LF    = 21'h00_000A;
  localparam char_t CH_CR    = 21'h00_000D;
  localparam char_t CH_SPACE = 21'h00_0020;
  localparam char_t CH_DQUOTE = 21'h00_0022;
  localparam char_t CH_COMMA = 21'h00_002C;
  localparam char_t CH_BSLASH = 21'h00_005C;
  localparam char_t CH_LET_N = 21'h00_006E;
  localparam char_t CH_LET_R = 21'h00_0072;
  localparam char_t CH_LET_T = 21'h00_0074;

  // Handling of data tabs, stray CRs in unquoted fields and newlines inside quoted fields.
  localparam logic [1:0] MODE_FAIL    = 2'd0;
  localparam logic [1:0] MODE_ESCAPE  = 2'd1;
  localparam logic [1:0] MODE_REPLACE = 2'd2;
  localparam logic [1:0] MODE_STRIP   = 2'd3;

  // Parser states.
  localparam logic [2:0] ST_OUTSIDE   = 3'd0;
  localparam logic [2:0] ST_QUOTED    = 3'd1;
  localparam logic [2:0] ST_QUOTE_SEEN = 3'd2;
  localparam logic [2:0] ST_UNQUOTED  = 3'd3;
  localparam logic [2:0] ST_UNQ_CR    = 3'd4;
  localparam logic [2:0] ST_BEFORE_NL = 3'd5;

  // Error codes.
  localparam logic [CODE_W-1:0] ERR_NONE         = 4'd0;
  localparam logic [CODE_W-1:0] ERR_TAB_DATA     = 4'd1;
  localparam logic [CODE_W-1:0] ERR_CR_DATA      = 4'd2;
  localparam logic [CODE_W-1:0] ERR_NL_DATA      = 4'd3;
  localparam logic [CODE_W-1:0] ERR_UNEXP_TAB    = 4'd4;
  localparam logic [CODE_W-1:0] ERR_UNEXP_BSLASH = 4'd5;
  localparam logic [CODE_W-1:0] ERR_UNEXP_QUOTE  = 4'd6;
  localparam logic [CODE_W-1:0] ERR_UNEXP_COMMA  = 4'd7;
  localparam logic [CODE_W-1:0] ERR_UNEXP_CR     = 4'd8;
  localparam logic [CODE_W-1:0] ERR_UNESC_QUOTE  = 4'd9;
  localparam logic [CODE_W-1:0] ERR_BAD_STATE    = 4'd10;
  localparam logic [CODE_W-1:0] ERR_UNTERM_QUOTE = 4'd11;

endpackage

@@ hw/rtl/c2t_in_if.sv @@
// Input channel carrying one character or an end marker per beat.
interface c2t_in_if;
  import c2t_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;
  logic  end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

@@ hw/rtl/c2t_out_if.sv @@
// Output channel carrying one converted character or one error report per beat.
interface c2t_out_if;
  import c2t_pkg::*;

  logic                valid;
  logic                ready;
  char_t               out_char;
  logic                error_flag;
  logic [CODE_W-1:0]   error_code;
  logic [REPORT_W-1:0] line_number;
  logic [REPORT_W-1:0] column_offset;
  logic                last_of_run;

  modport source (output valid, output out_char, output error_flag, output error_code,
                  output line_number, output column_offset, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_char, input error_flag, input error_code,
                  input line_number, input column_offset, input last_of_run,
                  output ready);
endinterface

@@ hw/rtl/csv_to_tsv_converter_core.sv @@
// CSV to tab-separated text converter: input register, parser step and result register.
//
// The converter takes one character code per input beat and turns CSV text into
// tab-separated text. Quotes are removed, a doubled quote inside a quoted field
// becomes one quote, a comma outside quotes becomes a tab and a CR directly before
// LF is dropped. Data tabs, unquoted stray CRs and quoted newlines are treated as
// the two-bit mode register says: fail, escape (backslash plus t, r or n, with every
// data backslash doubled), replace by a space, or strip. Each character gives zero
// to four output beats; the last beat of an input carries last_of_run. A fatal
// condition gives a single error beat with a code and the line and offset counts,
// after which characters are dropped until an end item arrives. An end item
// reports an unterminated quote if one is open and resets the parser and counters;
// the mode register keeps its value. The mode register should only be written while
// the converter is idle. An accepted beat is held in the input register until the
// result register is free; the parser step runs combinationally from there and loads
// the four-entry result register, which offers the output beats one by one.
// The result register sends one beat per cycle while out_o.ready is high, which sets
// the rate: inputs giving at most one result each stream at one per cycle. While a
// result waits on back-pressure, one further input beat is still taken into the
// input register. There is no reset sweep; the block is ready straight after reset.
module csv_to_tsv_converter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  c2t_in_if.sink            in_i,
  c2t_out_if.source         out_o
);
  import c2t_pkg::*;

  // Up to four characters produced by one parser step.
  typedef struct packed {
    logic [3:0][CHAR_W-1:0] chars;
    logic [2:0]             cnt;
  } burst_t;

  function automatic burst_t put_ch(burst_t b, char_t c);
    burst_t r;
    r = b;
    if (b.cnt < 3'd4) begin
      r.chars[b.cnt[1:0]] = c;
      r.cnt               = b.cnt + 3'd1;
    end
    return r;
  endfunction

  // Output side of an invalid character in the non-failing modes.
  function automatic burst_t bad_put(burst_t b, logic [1:0] mode, char_t letter);
    burst_t r;
    r = b;
    unique case (mode)
      MODE_ESCAPE: begin
        r = put_ch(r, CH_BSLASH);
        r = put_ch(r, letter);
      end
      MODE_REPLACE: r = put_ch(r, CH_SPACE);
      default: r = b;
    endcase
    return r;
  endfunction

  // The first fatal condition of a step is the one reported.
  function automatic logic [CODE_W-1:0] first_err(logic [CODE_W-1:0] err,
                                                   logic [CODE_W-1:0] code);
    return (err != ERR_NONE) ? err : code;
  endfunction

  function automatic logic [CODE_W-1:0] bad_err(logic [CODE_W-1:0] err, logic [1:0] mode,
                                                 logic [CODE_W-1:0] code);
    return (mode == MODE_FAIL) ? first_err(err, code) : err;
  endfunction

  function automatic logic [REPORT_W-1:0] to_report(count_t v);
    logic [COUNT_BITS+REPORT_W-1:0] w;
    w = {{REPORT_W{1'b0}}, v};
    return w[REPORT_W-1:0];
  endfunction

  localparam count_t CountOne = count_t'(1);

  // Configuration and parser state.
  logic [1:0] mode_q;
  logic [2:0] state_q, state_d;
  count_t     line_q, line_d;
  count_t     off_q, off_d;
  logic       halted_q, halted_d;

  // Input register.
  logic  inq_valid_q;
  char_t inq_char_q;
  logic  inq_eoi_q;

  // Result register: either one error report or up to four characters.
  logic                   bq_valid_q, bq_valid_d;
  logic                   bq_err_q, bq_err_d;
  logic [CODE_W-1:0]      bq_code_q, bq_code_d;
  logic [REPORT_W-1:0]    bq_line_q, bq_line_d;
  logic [REPORT_W-1:0]    bq_off_q, bq_off_d;
  logic [3:0][CHAR_W-1:0] bq_chars_q, bq_chars_d;
  logic [1:0]             bq_last_q, bq_last_d;
  logic [1:0]             bq_idx_q;

  logic out_fire, bq_last_beat, advance, in_fire;

  assign out_fire     = out_o.valid && out_o.ready;
  assign bq_last_beat = bq_err_q || (bq_idx_q == bq_last_q);
  // The held item moves into the result register once the previous results are gone.
  assign advance      = inq_valid_q && (!bq_valid_q || (out_fire && bq_last_beat));
  assign in_i.ready   = !inq_valid_q || advance;
  assign in_fire      = in_i.valid && in_i.ready;

  // Parser step on the held item.
  always_comb begin
    logic [2:0]        s;
    logic [CODE_W-1:0] err;
    burst_t            b;
    logic              is_nl;
    char_t             ch;

    ch      = inq_char_q;
    s       = state_q;
    err     = ERR_NONE;
    b       = '0;
    is_nl   = (ch == CH_LF);

    state_d    = state_q;
    line_d     = line_q;
    off_d      = off_q;
    halted_d   = halted_q;
    bq_valid_d = 1'b0;
    bq_err_d   = 1'b0;
    bq_code_d  = ERR_NONE;
    bq_line_d  = '0;
    bq_off_d   = '0;
    bq_chars_d = '0;
    bq_last_d  = '0;

    if (is_nl) begin
      if (line_q != '1) begin
        line_d = line_q + CountOne;
      end
      off_d = '0;
    end else if (off_q != '1) begin
      off_d = off_q + CountOne;
    end

    if (s > ST_BEFORE_NL) begin
      err = first_err(err, ERR_BAD_STATE);
    end else if (ch == CH_TAB) begin
      if (s == ST_OUTSIDE || s == ST_QUOTED || s == ST_UNQUOTED) begin
        s   = (s == ST_QUOTED) ? ST_QUOTED : ST_UNQUOTED;
        err = bad_err(err, mode_q, ERR_TAB_DATA);
        b   = bad_put(b, mode_q, CH_LET_T);
      end else if (s == ST_UNQ_CR) begin
        s   = ST_UNQUOTED;
        err = bad_err(err, mode_q, ERR_CR_DATA);
        b   = bad_put(b, mode_q, CH_LET_R);
        err = bad_err(err, mode_q, ERR_TAB_DATA);
        b   = bad_put(b, mode_q, CH_LET_T);
      end else begin
        err = first_err(err, ERR_UNEXP_TAB);
      end
    end else if (ch == CH_BSLASH) begin
      if (s == ST_QUOTE_SEEN || s == ST_BEFORE_NL) begin
        err = first_err(err, ERR_UNEXP_BSLASH);
      end else begin
        if (s == ST_UNQ_CR) begin
          err = bad_err(err, mode_q, ERR_CR_DATA);
          b   = bad_put(b, mode_q, CH_LET_R);
        end
        if (s != ST_QUOTED) begin
          s = ST_UNQUOTED;
        end
        if (mode_q == MODE_ESCAPE) begin
          b = put_ch(b, CH_BSLASH);
        end
        b = put_ch(b, CH_BSLASH);
      end
    end else if (ch == CH_DQUOTE) begin
      if (s == ST_OUTSIDE) begin
        s = ST_QUOTED;
      end else if (s == ST_QUOTED) begin
        s = ST_QUOTE_SEEN;
      end else if (s == ST_QUOTE_SEEN) begin
        b = put_ch(b, CH_DQUOTE);
        s = ST_QUOTED;
      end else begin
        err = first_err(err, ERR_UNEXP_QUOTE);
      end
    end else if (ch == CH_COMMA) begin
      if (s == ST_QUOTED) begin
        b = put_ch(b, CH_COMMA);
      end else if (s == ST_BEFORE_NL) begin
        err = first_err(err, ERR_UNEXP_COMMA);
      end else begin
        if (s == ST_UNQ_CR) begin
          err = bad_err(err, mode_q, ERR_CR_DATA);
          b   = bad_put(b, mode_q, CH_LET_R);
        end
        b = put_ch(b, CH_TAB);
        s = ST_OUTSIDE;
      end
    end else if (is_nl) begin
      if (s == ST_QUOTED) begin
        err = bad_err(err, mode_q, ERR_NL_DATA);
        b   = bad_put(b, mode_q, CH_LET_N);
      end else begin
        b = put_ch(b, CH_LF);
        s = ST_OUTSIDE;
      end
    end else if (ch == CH_CR) begin
      if (s == ST_QUOTED) begin
        s = ST_QUOTED;
      end else if (s == ST_QUOTE_SEEN || s == ST_OUTSIDE) begin
        s = ST_BEFORE_NL;
      end else if (s == ST_UNQ_CR) begin
        err = bad_err(err, mode_q, ERR_CR_DATA);
        b   = bad_put(b, mode_q, CH_LET_R);
      end else if (s == ST_UNQUOTED) begin
        s = ST_UNQ_CR;
      end else begin
        err = first_err(err, ERR_UNEXP_CR);
      end
    end else begin
      if (s == ST_OUTSIDE || s == ST_QUOTED || s == ST_UNQUOTED) begin
        b = put_ch(b, ch);
        s = (s == ST_QUOTED) ? ST_QUOTED : ST_UNQUOTED;
      end else if (s == ST_QUOTE_SEEN) begin
        err = first_err(err, ERR_UNESC_QUOTE);
      end else if (s == ST_UNQ_CR) begin
        s   = ST_UNQUOTED;
        err = bad_err(err, mode_q, ERR_CR_DATA);
        b   = bad_put(b, mode_q, CH_LET_R);
        b   = put_ch(b, ch);
      end else begin
        err = first_err(err, ERR_BAD_STATE);
      end
    end

    if (inq_eoi_q) begin
      // End item: report an open quote, then start afresh.
      line_d   = CountOne;
      off_d    = '0;
      state_d  = ST_OUTSIDE;
      halted_d = 1'b0;
      if (!halted_q && state_q == ST_QUOTED) begin
        bq_valid_d = 1'b1;
        bq_err_d   = 1'b1;
        bq_code_d  = ERR_UNTERM_QUOTE;
        bq_line_d  = to_report(line_q);
        bq_off_d   = to_report(off_q);
      end
    end else if (halted_q) begin
      line_d = line_q;
      off_d  = off_q;
    end else if (err != ERR_NONE) begin
      halted_d   = 1'b1;
      bq_valid_d = 1'b1;
      bq_err_d   = 1'b1;
      bq_code_d  = err;
      bq_line_d  = to_report(line_d);
      bq_off_d   = to_report(off_d);
    end else begin
      state_d    = s;
      bq_valid_d = (b.cnt != 3'd0);
      bq_chars_d = b.chars;
      bq_last_d  = b.cnt[1:0] - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FAIL;
      state_q     <= ST_OUTSIDE;
      line_q      <= CountOne;
      off_q       <= '0;
      halted_q    <= 1'b0;
      inq_valid_q <= 1'b0;
      bq_valid_q  <= 1'b0;
      bq_idx_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        inq_valid_q <= 1'b1;
      end else if (advance) begin
        inq_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q    <= state_d;
        line_q     <= line_d;
        off_q      <= off_d;
        halted_q   <= halted_d;
        bq_valid_q <= bq_valid_d;
        bq_idx_q   <= '0;
      end else if (out_fire) begin
        if (bq_last_beat) begin
          bq_valid_q <= 1'b0;
          bq_idx_q   <= '0;
        end else begin
          bq_idx_q <= bq_idx_q + 2'd1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      inq_char_q <= in_i.char_code;
      inq_eoi_q  <= in_i.end_of_input;
    end
    if (advance) begin
      bq_err_q   <= bq_err_d;
      bq_code_q  <= bq_code_d;
      bq_line_q  <= bq_line_d;
      bq_off_q   <= bq_off_d;
      bq_chars_q <= bq_chars_d;
      bq_last_q  <= bq_last_d;
    end
  end

  assign out_o.valid         = bq_valid_q;
  assign out_o.out_char      = bq_err_q ? '0 : bq_chars_q[bq_idx_q];
  assign out_o.error_flag    = bq_err_q;
  assign out_o.error_code    = bq_code_q;
  assign out_o.line_number   = bq_line_q;
  assign out_o.column_offset = bq_off_q;
  assign out_o.last_of_run   = bq_last_beat;

  // A pending parser error report means the parser is halted.
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bq_valid_q && bq_err_q && bq_code_q != ERR_UNTERM_QUOTE) |-> halted_q)
    else $error("error report pending while the parser is not halted");

  // The beat index never runs past the last loaded character.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bq_valid_q && !bq_err_q) |-> (bq_idx_q <= bq_last_q))
    else $error("result beat index beyond the loaded characters");

  // An error report is a single beat.
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bq_valid_q && bq_err_q) |-> (bq_idx_q == 2'd0))
    else $error("error report spans more than one beat");

  // A halted parser only leaves its state on an end item.
  a_halt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halted_q && !(advance && inq_eoi_q)) |=> (state_q == $past(state_q) && halted_q))
    else $error("halted parser changed state without an end item");

endmodule
